>>> rtl/fsft_pkg.sv
// Shared types, widths and constants of the fixed step frame timer.
package fsft_pkg;

	// canonical ticks per second, default of the top-level parameter
	localparam int unsigned TPS_DEF      = 10000000;
	localparam int unsigned SNAP_DIVISOR = 4000;

	localparam int unsigned MODE_W     = 1;
	localparam int unsigned TARGET_W   = 24;
	localparam int unsigned FREQ_W     = 32;
	localparam int unsigned MAXD_W     = 29;
	localparam int unsigned COUNT_W    = 64;
	localparam int unsigned STEP_W     = 20;
	localparam int unsigned ELAPSED_W  = 24;
	localparam int unsigned TOTAL_W    = 64;
	localparam int unsigned FRAMES_W   = 32;
	localparam int unsigned FPS_W      = 32;
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned S_TDATA_W  = 64;
	localparam int unsigned S_TUSER_W  = 1;
	localparam int unsigned M_TDATA_W  = 176;

	// register reset values
	localparam logic [TARGET_W-1:0] TARGET_RST = 24'd166666;
	localparam logic [FREQ_W-1:0]   FREQ_RST   = 32'd10000000;
	localparam logic [MAXD_W-1:0]   MAXD_RST   = 29'd1000000;

	// input command codes
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MODE   = 2'd0,
		REG_TARGET = 2'd1,
		REG_FREQ   = 2'd2,
		REG_MAXD   = 2'd3
	} cfg_reg_t;

	// shared restoring divider
	localparam int unsigned DVD_W  = 64;
	localparam int unsigned REM_W  = 32;
	localparam int unsigned ITER_W = 7;

	localparam logic [ITER_W-1:0] ITERS_SCALE = 7'd24;
	localparam logic [ITER_W-1:0] ITERS_STEPS = 7'd25;
	localparam logic [ITER_W-1:0] ITERS_MOD   = 7'd64;

	typedef struct packed {
		logic              start;
		logic [REM_W-1:0]  rem;   // partial remainder preload, below divisor
		logic [DVD_W-1:0]  dvd;   // dividend bits, consumed from the MSB
		logic [REM_W-1:0]  dsr;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;   // quotient in the low iters bits
		logic [REM_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> rtl/fixed_step_frame_timer.sv
// Fixed time step frame timer: sequencer, state and output register.
//
// One item per display frame enters on the s_ group: tuser carries the command
// (tick or restart), tdata the 64-bit free-running counter reading. Each item
// yields exactly one result transfer on the m_ group: steps taken, length of
// the last step, total time, frame count and frames per second.
// Settings are to be written through cfg_we/cfg_addr/cfg_wdata while the
// block idles; the block itself does not enforce this. A restart goes straight
// to the output stage. A tick in fixed-step mode also counts whole steps and
// skips the step total when none is taken; a rescale that saturates skips the
// divider. A tick that closes a second adds the accumulator modulo. The
// single bit-serial divider does the divisions: 24 iterations to rescale the
// delta, 25 to count whole steps, 64 to reduce the accumulator.
// s_tready is high only while the sequencer is idle, so one item is in work
// at a time. The result sits in an output register; a new item is taken while
// it waits, and the sequencer holds in its last state until the slot frees up.
// Reset (arst_n low) clears all timing state and loads the default settings:
// variable step, 1/60 s target, 10 MHz counter, 0.1 s delta clamp.
module fixed_step_frame_timer #(
	parameter int unsigned TICKS_PER_SECOND = fsft_pkg::TPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [fsft_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fsft_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fsft_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] counter_value
	input  logic [fsft_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] command
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [19:0] step_count, [43:20] elapsed_ticks, [107:44] total_ticks,
	// [139:108] frame_count, [171:140] frames_per_second, [175:172] zero
	output logic [fsft_pkg::M_TDATA_W-1:0]  m_tdata
);
	import fsft_pkg::*;

	localparam logic [FREQ_W-1:0]   TPS_VAL  = FREQ_W'(TICKS_PER_SECOND);
	localparam logic [TARGET_W-1:0] SNAP_LIM = TARGET_W'(TICKS_PER_SECOND / SNAP_DIVISOR);
	localparam int unsigned         PAD_W    = M_TDATA_W - STEP_W - ELAPSED_W - TOTAL_W
	                                           - FRAMES_W - FPS_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DELTA, ST_ACCUM, ST_MUL, ST_SCALE, ST_DIV, ST_MODE,
		ST_STEPS, ST_TOTAL, ST_RATE, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_SCALE, PH_STEPS, PH_MOD
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	// settings
	logic                mode_q;
	logic [TARGET_W-1:0] target_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [MAXD_W-1:0]   maxd_q;

	// timing state
	logic [COUNT_W-1:0]   last_q;
	logic [COUNT_W-1:0]   acc_q;       // raw counts inside the current second
	logic [TARGET_W-1:0]  leftover_q;  // below the target length it was last divided by
	logic [ELAPSED_W-1:0] step_len_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [FRAMES_W-1:0]  frames_q;
	logic [FRAMES_W-1:0]  fts_q;       // frames inside the current second
	logic [FPS_W-1:0]     rate_q;

	// per-item working registers
	logic                 cmd_q;
	logic [COUNT_W-1:0]   reading_q;
	logic [COUNT_W-1:0]   delta_q;
	logic [FREQ_W-1:0]    mul_a_q;
	logic [FREQ_W-1:0]    mul_b_q;
	logic [COUNT_W-1:0]   prod_q;
	logic [TARGET_W-1:0]  scaled_q;
	logic [STEP_W-1:0]    steps_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     div_start_q;
	logic [REM_W-1:0]  div_rem_q;
	logic [DVD_W-1:0]  div_dvd_q;
	logic [REM_W-1:0]  div_dsr_q;
	logic [ITER_W-1:0] div_iters_q;

	// combinational helpers
	logic                in_xfer;
	logic                out_free;
	logic [FREQ_W-1:0]   freq_eff;
	logic [TARGET_W-1:0] target_eff;
	logic [MAXD_W-1:0]   delta_clamp;
	logic [TARGET_W-1:0] snap_diff;
	logic [TARGET_W-1:0] snapped;
	logic [TARGET_W:0]   step_sum;
	logic                scale_sat;
	logic [STEP_W-1:0]   steps_sat;
	logic                sec_done;

	assign in_xfer    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	// a zero frequency or target behaves as one
	assign freq_eff   = (freq_q == '0) ? FREQ_W'(1) : freq_q;
	assign target_eff = (target_q == '0) ? TARGET_W'(1) : target_q;

	assign delta_clamp = (delta_q > {{(COUNT_W-MAXD_W){1'b0}}, maxd_q}) ? maxd_q
	                     : delta_q[MAXD_W-1:0];

	// quotient would not fit 24 bits: saturate without dividing
	assign scale_sat = prod_q >= {{(COUNT_W-FREQ_W-TARGET_W){1'b0}}, freq_eff,
	                              {TARGET_W{1'b0}}};

	// snap a step close to the target onto the target
	assign snap_diff = (scaled_q > target_eff) ? (scaled_q - target_eff)
	                   : (target_eff - scaled_q);
	assign snapped   = (snap_diff < SNAP_LIM) ? target_eff : scaled_q;
	assign step_sum  = {1'b0, leftover_q} + {1'b0, scaled_q};

	assign steps_sat = (div_rsp.quo[TARGET_W:STEP_W] != '0) ? {STEP_W{1'b1}}
	                   : div_rsp.quo[STEP_W-1:0];

	assign sec_done  = acc_q >= {{(COUNT_W-FREQ_W){1'b0}}, freq_eff};

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SCALE;
			mode_q      <= 1'b0;
			target_q    <= TARGET_RST;
			freq_q      <= FREQ_RST;
			maxd_q      <= MAXD_RST;
			last_q      <= '0;
			acc_q       <= '0;
			leftover_q  <= '0;
			step_len_q  <= '0;
			total_q     <= '0;
			frames_q    <= '0;
			fts_q       <= '0;
			rate_q      <= '0;
			m_tvalid_q  <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_addr))
					REG_MODE:   mode_q   <= cfg_wdata[0];
					REG_TARGET: target_q <= cfg_wdata[TARGET_W-1:0];
					REG_FREQ:   freq_q   <= cfg_wdata[FREQ_W-1:0];
					REG_MAXD:   maxd_q   <= cfg_wdata[MAXD_W-1:0];
					default:    ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tuser[0] == CMD_RESTART) begin
							last_q     <= s_tdata;
							leftover_q <= '0;
							acc_q      <= '0;
							fts_q      <= '0;
							rate_q     <= '0;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_DELTA;
						end
					end
				end
				ST_DELTA: begin
					last_q  <= reading_q;
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					acc_q   <= acc_q + delta_q;
					phase_q <= PH_SCALE;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= (phase_q == PH_SCALE) ? ST_SCALE : ST_TOTAL;
				end
				ST_SCALE: begin
					if (scale_sat) begin
						state_q <= ST_MODE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						unique case (phase_q)
							PH_SCALE: state_q <= ST_MODE;
							PH_STEPS: begin
								leftover_q <= div_rsp.rem[TARGET_W-1:0];
								state_q    <= (steps_sat != '0) ? ST_MUL : ST_RATE;
							end
							PH_MOD: begin
								acc_q   <= {{(COUNT_W-REM_W){1'b0}}, div_rsp.rem};
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MODE: begin
					if (mode_q) begin
						state_q <= ST_STEPS;
					end else begin
						step_len_q <= scaled_q;
						total_q    <= total_q + {{(TOTAL_W-TARGET_W){1'b0}}, scaled_q};
						leftover_q <= '0;
						frames_q   <= frames_q + FRAMES_W'(1);
						fts_q      <= fts_q + FRAMES_W'(1);
						state_q    <= ST_RATE;
					end
				end
				ST_STEPS: begin
					div_start_q <= 1'b1;
					phase_q     <= PH_STEPS;
					state_q     <= ST_DIV;
				end
				ST_TOTAL: begin
					total_q    <= total_q + prod_q;
					step_len_q <= target_eff;
					frames_q   <= frames_q + {{(FRAMES_W-STEP_W){1'b0}}, steps_q};
					fts_q      <= fts_q + FRAMES_W'(1);
					state_q    <= ST_RATE;
				end
				ST_RATE: begin
					if (sec_done) begin
						rate_q      <= fts_q;
						fts_q       <= '0;
						div_start_q <= 1'b1;
						phase_q     <= PH_MOD;
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-item working registers and divider operands
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd_q     <= s_tuser[0];
					reading_q <= s_tdata;
					steps_q   <= '0;
				end
			end
			ST_DELTA: delta_q <= reading_q - last_q;
			ST_ACCUM: begin
				mul_a_q <= {{(FREQ_W-MAXD_W){1'b0}}, delta_clamp};
				mul_b_q <= TPS_VAL;
			end
			ST_MUL: prod_q <= COUNT_W'(mul_a_q) * COUNT_W'(mul_b_q);
			ST_SCALE: begin
				if (scale_sat) begin
					scaled_q <= {TARGET_W{1'b1}};
				end else begin
					div_rem_q   <= prod_q[TARGET_W +: REM_W];
					div_dvd_q   <= {prod_q[TARGET_W-1:0], {(DVD_W-TARGET_W){1'b0}}};
					div_dsr_q   <= freq_eff;
					div_iters_q <= ITERS_SCALE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					if (phase_q == PH_SCALE) begin
						scaled_q <= div_rsp.quo[TARGET_W-1:0];
					end else if (phase_q == PH_STEPS) begin
						steps_q <= steps_sat;
						mul_a_q <= {{(FREQ_W-STEP_W){1'b0}}, steps_sat};
						mul_b_q <= {{(FREQ_W-TARGET_W){1'b0}}, target_eff};
					end
				end
			end
			ST_MODE: begin
				if (mode_q) begin
					scaled_q <= snapped;
				end else begin
					steps_q <= STEP_W'(1);
				end
			end
			ST_STEPS: begin
				div_rem_q   <= '0;
				div_dvd_q   <= {step_sum, {(DVD_W-TARGET_W-1){1'b0}}};
				div_dsr_q   <= {{(REM_W-TARGET_W){1'b0}}, target_eff};
				div_iters_q <= ITERS_STEPS;
			end
			ST_RATE: begin
				div_rem_q   <= '0;
				div_dvd_q   <= acc_q;
				div_dsr_q   <= freq_eff;
				div_iters_q <= ITERS_MOD;
			end
			ST_OUT: begin
				if (out_free) begin
					// a restart reports no steps
					m_tdata_q <= {{PAD_W{1'b0}}, rate_q, frames_q, total_q, step_len_q,
					              (cmd_q == CMD_TICK) ? steps_q : {STEP_W{1'b0}}};
				end
			end
			default: ;
		endcase
	end

	assign div_req.start = div_start_q;
	assign div_req.rem   = div_rem_q;
	assign div_req.dvd   = div_dvd_q;
	assign div_req.dsr   = div_dsr_q;
	assign div_req.iters = div_iters_q;

	fsft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/fsft_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module fsft_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fsft_pkg::div_req_t req,
	output fsft_pkg::div_rsp_t rsp
);
	import fsft_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [REM_W-1:0]  dsr_q;

	logic [REM_W:0]   shifted;
	logic [REM_W+1:0] trial;
	logic             qbit;
	logic [REM_W-1:0] rem_next;

	assign shifted  = {rem_q, dvd_q[DVD_W-1]};
	assign trial    = {1'b0, shifted} - {2'b0, dsr_q};
	assign qbit     = ~trial[REM_W+1];
	assign rem_next = qbit ? trial[REM_W-1:0] : shifted[REM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			dvd_q <= req.dvd;
			dsr_q <= req.dsr;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/fsft_checker.sv
// Port-level checks of the frame timer and their bind to the top level.
module fsft_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [fsft_pkg::M_TDATA_W-1:0]  m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the block is busy right after taking an item
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after an input transfer");

	// a new result only comes out of an item in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

	// no result in the cycle right after an input transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind fixed_step_frame_timer fsft_checker u_fsft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> verif/tb.sv
// Self-checking testbench for fixed_step_frame_timer with a transaction-level timer predictor.
`timescale 1ns / 1ps

// Tracks the timer state the way the block should, and holds the results still owed.
class frame_timer_tracker;
	typedef struct {
		logic [fsft_pkg::STEP_W-1:0]    steps;
		logic [fsft_pkg::ELAPSED_W-1:0] elapsed;
		logic [fsft_pkg::TOTAL_W-1:0]   total;
		logic [fsft_pkg::FRAMES_W-1:0]  frames;
		logic [fsft_pkg::FPS_W-1:0]     fps;
	} timer_report_t;

	// settings, as last written
	logic                            fixed_mode;
	logic [fsft_pkg::TARGET_W-1:0]   step_target;
	logic [fsft_pkg::FREQ_W-1:0]     count_freq;
	logic [fsft_pkg::MAXD_W-1:0]     delta_clamp;

	// timing state
	logic [63:0] prev_reading;
	logic [63:0] raw_in_second;
	logic [31:0] carry_ticks;
	logic [23:0] step_len;
	logic [63:0] time_total;
	logic [31:0] frames_total;
	logic [31:0] frames_in_second;
	logic [31:0] fps_rate;

	timer_report_t expected_reports[$];
	int            mismatches;

	function new();
		fixed_mode       = 1'b0;
		step_target      = fsft_pkg::TARGET_RST;
		count_freq       = fsft_pkg::FREQ_RST;
		delta_clamp      = fsft_pkg::MAXD_RST;
		prev_reading     = '0;
		raw_in_second    = '0;
		carry_ticks      = '0;
		step_len         = '0;
		time_total       = '0;
		frames_total     = '0;
		frames_in_second = '0;
		fps_rate         = '0;
		mismatches       = 0;
	endfunction

	function void set_settings(logic mode, logic [23:0] tgt, logic [31:0] freq,
			logic [28:0] maxd);
		fixed_mode  = mode;
		step_target = tgt;
		count_freq  = freq;
		delta_clamp = maxd;
	endfunction

	function int pending();
		return expected_reports.size();
	endfunction

	// Advances the timer by one accepted transfer and queues the report it owes.
	function void note_item(logic cmd, logic [63:0] reading);
		logic [63:0]   freq, tgt, delta, scaled, gap, acc, n;
		timer_report_t rpt;
		freq = (count_freq == 0) ? 64'd1 : 64'(count_freq);
		tgt  = (step_target == 0) ? 64'd1 : 64'(step_target);
		rpt.steps = '0;
		if (cmd == fsft_pkg::CMD_RESTART) begin
			prev_reading     = reading;
			carry_ticks      = '0;
			raw_in_second    = '0;
			frames_in_second = '0;
			fps_rate         = '0;
		end else begin
			delta         = reading - prev_reading;
			prev_reading  = reading;
			raw_in_second = raw_in_second + delta;
			if (delta > 64'(delta_clamp))
				delta = 64'(delta_clamp);
			scaled = delta * 64'(fsft_pkg::TPS_DEF) / freq;
			if (scaled > 64'hFF_FFFF)
				scaled = 64'hFF_FFFF;
			if (fixed_mode) begin
				gap = (scaled > tgt) ? scaled - tgt : tgt - scaled;
				if (gap < 64'(fsft_pkg::TPS_DEF / fsft_pkg::SNAP_DIVISOR))
					scaled = tgt;
				acc         = 64'(carry_ticks) + scaled;
				n           = acc / tgt;
				carry_ticks = 32'(acc % tgt);
				// surplus steps beyond the counter width are dropped
				if (n > 64'hF_FFFF)
					n = 64'hF_FFFF;
				rpt.steps = 20'(n);
				if (n != 0) begin
					step_len     = 24'(tgt);
					time_total   = time_total + n * tgt;
					frames_total = frames_total + 32'(n);
				end
			end else begin
				step_len     = 24'(scaled);
				time_total   = time_total + scaled;
				carry_ticks  = '0;
				frames_total = frames_total + 32'd1;
				rpt.steps    = 20'd1;
			end
			if (rpt.steps != 0)
				frames_in_second = frames_in_second + 32'd1;
			if (raw_in_second >= freq) begin
				fps_rate         = frames_in_second;
				frames_in_second = '0;
				raw_in_second    = raw_in_second % freq;
			end
		end
		rpt.elapsed = step_len;
		rpt.total   = time_total;
		rpt.frames  = frames_total;
		rpt.fps     = fps_rate;
		expected_reports.push_back(rpt);
	endfunction

	// Compares one result transfer against the oldest report still owed.
	function void check_result(logic [fsft_pkg::M_TDATA_W-1:0] data);
		timer_report_t rpt;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d: result with none expected, data %h", mismatches, data);
			return;
		end
		rpt = expected_reports.pop_front();
		if (data[19:0] !== rpt.steps || data[43:20] !== rpt.elapsed
				|| data[107:44] !== rpt.total || data[139:108] !== rpt.frames
				|| data[171:140] !== rpt.fps || data[175:172] !== 4'd0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d (exp/act): steps %0d/%0d elapsed %0d/%0d",
					mismatches, rpt.steps, data[19:0], rpt.elapsed, data[43:20],
					" total %h/%h frames %0d/%0d fps %0d/%0d pad %h",
					rpt.total, data[107:44], rpt.frames, data[139:108],
					rpt.fps, data[171:140], data[175:172]);
		end
	endfunction
endclass

module tb;
	import fsft_pkg::*;

	localparam int NUM_PHASES       = 10;
	localparam int ITEMS_PER_PHASE  = 173;  // plus 19 directed, about 1750 in all
	localparam int HOLD_OFF_CYCLES  = 400;  // long receiver stall, fills the block
	localparam int DRAIN_CYCLES     = 200;  // settle time after the last result is drained
	localparam longint TIMEOUT_NS   = 20_000_000;  // simulation timeout, several times the worst-case run

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // [63:0] counter_value
	logic [S_TUSER_W-1:0]  s_tuser;   // [0] command
	logic                  m_tvalid;
	logic                  m_tready;
	// [19:0] step_count, [43:20] elapsed_ticks, [107:44] total_ticks,
	// [139:108] frame_count, [171:140] frames_per_second, [175:172] zero
	logic [M_TDATA_W-1:0]  m_tdata;

	frame_timer_tracker tracker;

	// Idle rates in percent, set per phase; zero means back-to-back traffic.
	int unsigned gap_pct;
	int unsigned stall_pct;
	bit          hold_off_req;

	// The sender's own view of the free-running counter.
	logic [63:0] reading;

	fixed_step_frame_timer #(
		.TICKS_PER_SECOND(TPS_DEF)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Raw counter advance for one display frame under the current settings: mostly
	// near the target (both sides of the snap window), some odd lengths, some
	// multi-step frames.
	function automatic logic [63:0] frame_raw();
		logic [63:0] tgt, freq, len;
		int unsigned pick;
		tgt  = (tracker.step_target == 0) ? 64'd1 : 64'(tracker.step_target);
		freq = (tracker.count_freq == 0) ? 64'd1 : 64'(tracker.count_freq);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			len = tgt + 64'($urandom_range(0, 6000));
			len = (len > 64'd3000) ? len - 64'd3000 : 64'd0;
		end else if (pick < 85) begin
			len = 64'($urandom_range(0, 32'(2 * tgt)));
		end else begin
			len = tgt * 64'($urandom_range(2, 5));
		end
		return len * freq / 64'(TPS_DEF) + 64'($urandom_range(0, 1));
	endfunction

	// Offers one item, with an optional idle burst first, and returns at the
	// accepting edge with tvalid still high.
	task automatic send_item(input logic cmd, input logic [63:0] value);
		int unsigned n;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			s_tdata  <= rand64();
			s_tuser  <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(cmd, value);
	endtask

	// Drops tvalid and waits for every owed result; the block is idle afterwards
	// since each item yields exactly one result.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic mode, input logic [23:0] tgt,
			input logic [31:0] freq, input logic [28:0] maxd);
		cfg_write(REG_MODE, 32'(mode));
		cfg_write(REG_TARGET, 32'(tgt));
		cfg_write(REG_FREQ, freq);
		cfg_write(REG_MAXD, 32'(maxd));
		cfg_we <= 1'b0;
		tracker.set_settings(mode, tgt, freq, maxd);
	endtask

	// One random item: mostly well-formed frame ticks, plus restarts, clamp-range
	// jumps and arbitrary readings (backwards and wrapping).
	task automatic random_item();
		int unsigned pick;
		logic        cmd;
		pick = $urandom_range(0, 99);
		cmd  = CMD_TICK;
		if (pick < 78) begin
			reading = reading + frame_raw();
		end else if (pick < 84) begin
			cmd = CMD_RESTART;
			if ($urandom_range(0, 3) == 0)
				reading = rand64();
		end else if (pick < 94) begin
			reading = reading + 64'($urandom_range(0, 32'(2 * tracker.delta_clamp + 1)));
		end else begin
			reading = rand64();
		end
		send_item(cmd, reading);
	endtask

	// Result sink: random stall bursts, plus one long hold-off on request.
	initial begin : result_sink
		int unsigned n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				n = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result monitor, sampled at the edge where the transfer happens.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	initial begin : stimulus
		logic        mode;
		logic [23:0] tgt;
		logic [31:0] freq;
		logic [28:0] maxd;

		tracker      = new();
		gap_pct      = 30;
		stall_pct    = 30;
		hold_off_req = 1'b0;
		reading      = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_MODE;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_TICK;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, variable step at reset settings.
		send_item(CMD_TICK, 64'd0);                      // tick before any restart
		send_item(CMD_TICK, 64'd166666);                 // one nominal frame
		send_item(CMD_RESTART, 64'hFFFF_FFFF_FFFF_FF00); // restart near the top
		send_item(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFF);    // all-ones reading
		send_item(CMD_TICK, 64'd166411);                 // counter wraps
		send_item(CMD_TICK, 64'd1166411);                // delta right at the clamp
		send_item(CMD_TICK, 64'd2166412);                // one above the clamp
		send_item(CMD_RESTART, 64'd0);
		// raw deltas beyond the clamp still count toward the second: fps after 4
		send_item(CMD_TICK, 64'd2500000);
		send_item(CMD_TICK, 64'd5000000);
		send_item(CMD_TICK, 64'd7500000);
		send_item(CMD_TICK, 64'd10000000);
		wait_drained();

		// Directed, fixed step at default target.
		write_settings(1'b1, TARGET_RST, FREQ_RST, MAXD_RST);
		send_item(CMD_RESTART, 64'd0);
		send_item(CMD_TICK, 64'd166666);                 // exact target
		send_item(CMD_TICK, 64'd334666);                 // inside snap window
		send_item(CMD_TICK, 64'd434666);                 // short frame, no step
		send_item(CMD_TICK, 64'd434666);                 // zero delta
		send_item(CMD_TICK, 64'd1434666);                // several steps plus carry
		send_item(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFF);    // far jump, clamped
		reading = 64'hFFFF_FFFF_FFFF_FFFF;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin mode = 1'b1; tgt = 24'd166666;  freq = 32'd10000000; maxd = 29'd1000000; end
				1: begin mode = 1'b0; tgt = 24'd166666;  freq = 32'd10000000; maxd = 29'd1000000; end
				// zero frequency, unit target: saturated scaling, step-count clamp
				2: begin mode = 1'b1; tgt = 24'd1;       freq = 32'd0;        maxd = 29'h1FFF_FFFF; end
				// zero target, no delta allowed through the clamp
				3: begin mode = 1'b1; tgt = 24'd0;       freq = 32'd1;        maxd = 29'd0; end
				4: begin mode = 1'b1; tgt = 24'hFF_FFFF; freq = 32'hFFFF_FFFF; maxd = 29'h1FFF_FFFF; end
				5: begin mode = 1'b0; tgt = 24'd10000000; freq = 32'd1000;    maxd = 29'd100; end
				6, 7: begin
					mode = (p == 6);
					tgt  = 24'($urandom_range(1, 10000000));
					freq = $urandom();
					maxd = 29'($urandom_range(0, 429496729));
				end
				8: begin mode = 1'b1; tgt = 24'd83333;   freq = 32'd24000000; maxd = 29'd2400000; end
				default: begin
					mode = 1'b1; tgt = 24'd166666; freq = 32'd10000000; maxd = 29'd1000000;
				end
			endcase
			write_settings(mode, tgt, freq, maxd);
			// phase 4 runs without gaps; the last phase is back-to-back throughout
			gap_pct   = (p == 4 || p == NUM_PHASES - 1) ? 0 : 30;
			stall_pct = gap_pct;
			if (p == 1)
				hold_off_req = 1'b1;
			repeat (ITEMS_PER_PHASE) random_item();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
